[design/its_pkg.sv]
package its_pkg;

   localparam int unsigned CFG_IDX_BITS = 3;
   localparam int unsigned CFG_DATA_BITS = 16;

   typedef enum logic [CFG_IDX_BITS-1:0] {
      REG_PROP_GAIN      = 3'd0,
      REG_DERIV_GAIN     = 3'd1,
      REG_SERVO_CENTER   = 3'd2,
      REG_SERVO_UPPER    = 3'd3,
      REG_SERVO_LOWER    = 3'd4,
      REG_LOST_THRESHOLD = 3'd5
   } reg_index_type;

   localparam logic [15:0] PROP_GAIN_RESET      = 16'hF100;
   localparam logic [15:0] DERIV_GAIN_RESET     = 16'hF380;
   localparam logic [15:0] SERVO_CENTER_RESET   = 16'd1500;
   localparam logic [15:0] SERVO_UPPER_RESET    = 16'd2000;
   localparam logic [15:0] SERVO_LOWER_RESET    = 16'd1000;
   localparam logic [9:0]  LOST_THRESHOLD_RESET = 10'd200;

   // Frame values after the floor always fit 16 bits.
   localparam int unsigned VAL_BITS = 16;
   localparam logic [VAL_BITS-1:0] VALUE_FLOOR = 16'd10;

   // Divider request/response between the top level and the serial divider.
   typedef struct packed {
      logic        start;
      logic [16:0] dividend;   // magnitude of (x-y), < 2^16
      logic [16:0] divisor;    // x+y, >= 20
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic        busy;
      logic [31:0] quotient;
   } div_rsp_type;

endpackage

[design/its_divider.sv]
// Restoring divider, one quotient bit per cycle: (dividend << 15) / divisor.
module its_divider (
   input  logic                clock,
   input  logic                reset,
   input  its_pkg::div_req_type req,
   output its_pkg::div_rsp_type rsp
);
   localparam int unsigned QB = 32;

   logic [QB-1:0] num_ff, num_in;
   logic [17:0]   rem_ff, rem_in;
   logic [16:0]   den_ff, den_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [17:0]   trial;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[16:0], num_ff[QB-1]};
      if (req.start) begin
         num_in  = {req.dividend[16:0], 15'd0};
         rem_in  = '0;
         den_in  = req.divisor;
         cnt_in  = 6'(QB);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[QB-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in    = trial - {1'b0, den_ff};
            num_in[0] = 1'b1;
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.busy     = busy_ff;
   assign rsp.quotient = num_ff;
endmodule

[design/its_mac.sv]
// Serial signed multiply: a (16b signed) times b (18b signed), one
// multiplier bit per cycle, shift-add into a 34-bit product.
module its_mac (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [15:0] mcand,
   input  logic signed [17:0] mplier,
   output logic               done,
   output logic signed [33:0] product
);
   logic signed [33:0] acc_ff, acc_in;
   logic signed [33:0] mc_ff, mc_in;
   logic [17:0]        mp_ff, mp_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   always_comb begin
      acc_in  = acc_ff;
      mc_in   = mc_ff;
      mp_in   = mp_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         mc_in   = 34'(mcand);
         mp_in   = mplier;
         cnt_in  = 5'd18;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Top multiplier bit carries negative weight.
         if (mp_ff[0]) begin
            if (cnt_ff == 5'd1) acc_in = acc_ff - mc_ff;
            else                acc_in = acc_ff + mc_ff;
         end
         mc_in  = mc_ff <<< 1;
         mp_in  = {1'b0, mp_ff[17:1]};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule

[design/inductive_track_steering.sv]
// Channel   | Dir | Handshake            | Beat contents
// req       | in  | req_valid/req_stall  | sample_a..sample_d
// rsp       | out | rsp_valid/rsp_stall  | servo_command, offsets, track_lost
// csr       | in  | csr_write_enable     | csr_index, csr_write_data
//
// A beat that does not complete a frame only shifts the sample lines. The
// frame-closing beat runs a sequencer: per channel a load, (ROUNDS_PER_FRAME-1)^2
// compare/swap steps, a serial sum of the middle samples and two restoring
// divides (by R-2, then by ten). Then two offset divides and two serial
// multiplies. Reset clears control state and configuration; the sample lines
// hold garbage until written. req_stall is high while a frame is processed; a
// finished frame waits in the output stage only while the previous result is
// still stalled on rsp.
module inductive_track_steering #(
   parameter int unsigned ROUNDS_PER_FRAME = 5,
   parameter int unsigned SAMPLE_BITS      = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sample_a,
   input  logic [SAMPLE_BITS-1:0] req_sample_b,
   input  logic [SAMPLE_BITS-1:0] req_sample_c,
   input  logic [SAMPLE_BITS-1:0] req_sample_d,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [15:0]            rsp_servo_command,
   output logic signed [15:0]     rsp_horizontal_offset,
   output logic signed [15:0]     rsp_vertical_offset,
   output logic                   rsp_track_lost,
   input  logic                   csr_write_enable,
   input  logic [its_pkg::CFG_IDX_BITS-1:0]  csr_index,
   input  logic [its_pkg::CFG_DATA_BITS-1:0] csr_write_data
);
   localparam int unsigned R   = ROUNDS_PER_FRAME;
   localparam int unsigned RB  = (R > 1) ? $clog2(R) : 1;
   localparam int unsigned RCB = $clog2(R + 1);
   localparam int unsigned SUMB = SAMPLE_BITS + $clog2(R);
   localparam int unsigned DIV3 = R - 2;
   localparam int unsigned CB   = $clog2(SUMB + 1);

   typedef enum logic [3:0] {
      ST_COLLECT, ST_SORT, ST_TRIM, ST_DIVT, ST_NEXTCH, ST_FLOOR,
      ST_HDIV, ST_VDIV, ST_MUL1, ST_MUL2, ST_CMD, ST_OUT
   } state_type;

   // configuration
   logic [15:0] prop_ff, deriv_ff, center_ff, upper_ff, lower_ff;
   logic [9:0]  thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_ff   <= its_pkg::PROP_GAIN_RESET;
         deriv_ff  <= its_pkg::DERIV_GAIN_RESET;
         center_ff <= its_pkg::SERVO_CENTER_RESET;
         upper_ff  <= its_pkg::SERVO_UPPER_RESET;
         lower_ff  <= its_pkg::SERVO_LOWER_RESET;
         thresh_ff <= its_pkg::LOST_THRESHOLD_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            its_pkg::REG_PROP_GAIN:      prop_ff   <= csr_write_data;
            its_pkg::REG_DERIV_GAIN:     deriv_ff  <= csr_write_data;
            its_pkg::REG_SERVO_CENTER:   center_ff <= csr_write_data;
            its_pkg::REG_SERVO_UPPER:    upper_ff  <= csr_write_data;
            its_pkg::REG_SERVO_LOWER:    lower_ff  <= csr_write_data;
            its_pkg::REG_LOST_THRESHOLD: thresh_ff <= csr_write_data[9:0];
            default: ;
         endcase
      end
   end

   // Per-channel sample shift lines: a beat shifts each line by one entry,
   // so a full frame leaves the R newest samples in place.
   logic [SAMPLE_BITS-1:0] line_ff [4][R];
   logic [SAMPLE_BITS-1:0] work_ff [R];
   logic [SAMPLE_BITS-1:0] work_in [R];

   state_type   state_ff;
   logic [RCB-1:0] round_ff;
   logic [1:0]  ch_ff;
   logic [RB-1:0] pos_ff;       // compare position within a pass
   logic [RB-1:0] pass_ff;
   logic [SUMB-1:0] sum_ff;     // dividend out at the top, quotient in at the bottom
   logic [3:0]  rem_ff;         // partial remainder of the constant divides
   logic [CB-1:0] dcnt_ff;      // quotient bits still to produce
   logic [15:0] val_ff [4];
   logic [15:0] prev_ff;
   logic        lost_ff;
   logic [15:0] hoff_ff, voff_ff;
   logic [15:0] cmd_ff;
   logic [15:0] rsp_hoff_ff, rsp_voff_ff;
   logic        rsp_lost_ff;
   logic        rsp_valid_ff;
   logic signed [33:0] p1_ff;
   logic        accept;
   logic        stage;          // 0: divide by R-2, 1: divide by 10 (also marks a started multiply)

   its_pkg::div_req_type dreq;
   its_pkg::div_rsp_type drsp;
   logic        mstart;
   logic signed [15:0] mcand;
   logic signed [17:0] mplier;
   logic        mdone;
   logic signed [33:0] mprod;

   its_divider u_div (.clock, .reset, .req(dreq), .rsp(drsp));
   its_mac u_mac (.clock, .reset, .start(mstart), .mcand, .mplier,
                  .done(mdone), .product(mprod));

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_COLLECT);

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < int'(R) - 1; i++) begin
            line_ff[0][i] <= line_ff[0][i+1];
            line_ff[1][i] <= line_ff[1][i+1];
            line_ff[2][i] <= line_ff[2][i+1];
            line_ff[3][i] <= line_ff[3][i+1];
         end
         line_ff[0][R-1] <= req_sample_a;
         line_ff[1][R-1] <= req_sample_b;
         line_ff[2][R-1] <= req_sample_c;
         line_ff[3][R-1] <= req_sample_d;
      end
   end

   // One restoring step of the constant divides: shift in the next
   // dividend bit, subtract the divisor when it fits.
   logic [4:0] dsel, dtrial;
   logic       dq;
   logic [3:0] dr;
   always_comb begin
      dsel   = stage ? 5'd10 : 5'(DIV3);
      dtrial = {rem_ff, sum_ff[SUMB-1]};
      dq     = dtrial >= dsel;
      dr     = dq ? 4'(dtrial - dsel) : dtrial[3:0];
   end

   // Operand selection for the divider: offset of a pair.
   logic [15:0] dx, dy;
   logic        neg_ff;
   always_comb begin
      if (state_ff == ST_FLOOR) begin
         dx = val_ff[0]; dy = val_ff[1];
      end else begin
         dx = val_ff[2]; dy = val_ff[3];
      end
      // Start the horizontal divide on the way out of the floor step and
      // the vertical one as soon as the horizontal quotient lands.
      dreq.start    = (state_ff == ST_FLOOR) || (state_ff == ST_HDIV && drsp.done);
      dreq.dividend = (dx >= dy) ? 17'(dx - dy) : 17'(dy - dx);
      dreq.divisor  = 17'(dx) + 17'(dy);
   end

   // Clamp quotient (magnitude) to Q1.15 and apply sign.
   function automatic logic [15:0] sat_off(input logic [31:0] q, input logic neg);
      logic [15:0] r;
      if (neg) r = (q >= 32'd32768) ? 16'h8000 : 16'(-q[15:0]);
      else     r = (q >= 32'd32767) ? 16'h7FFF : q[15:0];
      return r;
   endfunction

   logic [15:0]        cmd_c;
   logic [16:0]        habs;
   always_comb begin
      habs = hoff_ff[15] ? 17'(-$signed({hoff_ff[15], hoff_ff})) : {1'b0, hoff_ff};
   end

   // Exact command arithmetic in 41 bits.
   logic signed [40:0] wacc;
   logic signed [40:0] wq;
   always_comb begin
      wacc = 41'(p1_ff) + 41'(mprod) + $signed({2'b0, center_ff, 23'd0});
      // Truncate toward zero.
      if (wacc[40]) wq = -((-wacc) >>> 23);
      else          wq = wacc >>> 23;
      if (wq[40])                  cmd_c = 16'd0;
      else if (|wq[39:16])         cmd_c = 16'hFFFF;
      else                         cmd_c = wq[15:0];
      if (cmd_c > upper_ff) cmd_c = upper_ff;
      if (cmd_c < lower_ff) cmd_c = lower_ff;
      if (habs * 17'd50 < 17'd32768 && habs < 17'd656) cmd_c = center_ff;
   end

   logic signed [16:0] hdiff;
   assign hdiff = $signed({hoff_ff[15], hoff_ff}) - $signed({prev_ff[15], prev_ff});

   always_comb begin
      mcand  = $signed(prop_ff);
      mplier = 18'($signed(hoff_ff));
      if (state_ff == ST_MUL2) begin
         mcand  = $signed(deriv_ff);
         mplier = 18'(hdiff);
      end
   end

   always_comb begin
      for (int i = 0; i < int'(R); i++) work_in[i] = work_ff[i];
      if (pos_ff < RB'(R - 1) && work_ff[pos_ff] > work_ff[pos_ff + 1'b1]) begin
         work_in[pos_ff]        = work_ff[pos_ff + 1'b1];
         work_in[pos_ff + 1'b1] = work_ff[pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         round_ff     <= '0;
         prev_ff      <= '0;
         lost_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Raise a new result, or drop the one just taken.
         if (state_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall))
            rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall)
            rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_COLLECT: begin
               if (accept) begin
                  if (round_ff == RCB'(R - 1)) begin
                     round_ff <= '0;
                     ch_ff    <= 2'd0;
                     state_ff <= ST_SORT;
                     pos_ff   <= '0;
                     pass_ff  <= '0;
                  end else begin
                     round_ff <= round_ff + 1'b1;
                  end
               end
            end
            ST_SORT: begin
               // Load the channel's line, then bubble passes.
               for (int i = 0; i < int'(R); i++) work_ff[i] <= line_ff[ch_ff][i];
               pos_ff   <= '0;
               pass_ff  <= '0;
               state_ff <= ST_TRIM;
            end
            ST_TRIM: begin
               for (int i = 0; i < int'(R); i++) work_ff[i] <= work_in[i];
               if (pos_ff >= RB'(R - 2)) begin
                  pos_ff <= '0;
                  if (pass_ff == RB'(R - 2)) begin
                     state_ff <= ST_DIVT;
                     sum_ff   <= '0;
                     pass_ff  <= '0;
                  end else begin
                     pass_ff <= pass_ff + 1'b1;
                  end
               end else begin
                  pos_ff <= pos_ff + 1'b1;
               end
            end
            ST_DIVT: begin
               // Sum middle entries one per cycle, then divide by R-2 and
               // by ten, one quotient bit per cycle.
               if (pass_ff == '0 && pos_ff == '0) begin
                  pos_ff <= RB'(1);
                  sum_ff <= '0;
                  stage  <= 1'b0;
               end else if (pos_ff != '0 && pos_ff <= RB'(R - 2)) begin
                  sum_ff <= sum_ff + SUMB'(work_ff[pos_ff]);
                  pos_ff <= (pos_ff == RB'(R - 2)) ? '0 : pos_ff + 1'b1;
                  if (pos_ff == RB'(R - 2)) begin
                     pass_ff <= RB'(1);
                     dcnt_ff <= CB'(SUMB);
                     rem_ff  <= '0;
                  end
               end else if (dcnt_ff != '0) begin
                  sum_ff  <= {sum_ff[SUMB-2:0], dq};
                  rem_ff  <= dr;
                  dcnt_ff <= dcnt_ff - 1'b1;
               end else if (!stage) begin
                  stage   <= 1'b1;
                  dcnt_ff <= CB'(SUMB);
                  rem_ff  <= '0;
               end else begin
                  // Scale back to a multiple of ten.
                  val_ff[ch_ff] <= 16'({sum_ff, 3'b000}) + 16'({sum_ff, 1'b0});
                  state_ff <= ST_NEXTCH;
               end
            end
            ST_NEXTCH: begin
               if (ch_ff == 2'd3) begin
                  if (val_ff[0] < 16'(thresh_ff) && val_ff[1] < 16'(thresh_ff))
                     lost_ff <= 1'b1;
                  for (int c = 0; c < 4; c++)
                     if (val_ff[c] < its_pkg::VALUE_FLOOR)
                        val_ff[c] <= its_pkg::VALUE_FLOOR;
                  state_ff <= ST_FLOOR;
               end else begin
                  ch_ff    <= ch_ff + 2'd1;
                  state_ff <= ST_SORT;
               end
               pass_ff <= '0;
               pos_ff  <= '0;
            end
            ST_FLOOR: begin
               neg_ff   <= val_ff[0] < val_ff[1];
               state_ff <= ST_HDIV;
            end
            ST_HDIV: begin
               if (drsp.done) begin
                  hoff_ff  <= sat_off(drsp.quotient, neg_ff);
                  neg_ff   <= val_ff[2] < val_ff[3];
                  state_ff <= ST_VDIV;
               end
            end
            ST_VDIV: begin
               if (drsp.done) begin
                  voff_ff  <= sat_off(drsp.quotient, neg_ff);
                  state_ff <= ST_MUL1;
                  stage    <= 1'b0;
               end
            end
            ST_MUL1: begin
               if (!stage) stage <= 1'b1;
               else if (mdone) begin
                  p1_ff    <= mprod;
                  stage    <= 1'b0;
                  state_ff <= ST_MUL2;
               end
            end
            ST_MUL2: begin
               if (!stage) stage <= 1'b1;
               else if (mdone) state_ff <= ST_CMD;
            end
            ST_CMD: begin
               prev_ff  <= hoff_ff;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               // Hold until the output slot is free or frees this cycle.
               if (!rsp_valid_ff || !rsp_stall) begin
                  cmd_ff      <= cmd_c;
                  rsp_hoff_ff <= hoff_ff;
                  rsp_voff_ff <= voff_ff;
                  rsp_lost_ff <= lost_ff;
                  state_ff    <= ST_COLLECT;
               end
            end
            default: state_ff <= ST_COLLECT;
         endcase
      end
   end

   // Multiplier start, one cycle per product.
   assign mstart = ((state_ff == ST_MUL1) || (state_ff == ST_MUL2)) && !stage;

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_servo_command     = cmd_ff;
   assign rsp_horizontal_offset = rsp_hoff_ff;
   assign rsp_vertical_offset   = rsp_voff_ff;
   assign rsp_track_lost        = rsp_lost_ff;

   // A result never appears while the sequencer is mid-frame.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> state_ff == ST_COLLECT)
      else $error("result raised outside collect state");
   // A stalled result holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_servo_command)
         && $stable(rsp_horizontal_offset) && $stable(rsp_vertical_offset)
         && $stable(rsp_track_lost))
      else $error("stalled result changed");
   // Lost flag is sticky.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(lost_ff) |-> lost_ff)
      else $error("lost flag cleared");
endmodule
